>>> rtl/mwo_pkg.sv
// Shared types, widths and constants of the mecanum wheel odometry unit.
// Used by the serial multiplier, the serial divider and the top level.
package mwo_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TRIG_BITS_DEF   = 16;

    localparam int CNT_FIELD_W = 32;
    localparam int SUM_W       = 35;
    localparam int GAIN_W      = 32;
    localparam int RATE_W      = 10;
    localparam int STEP_W      = 47;
    localparam int POSE_W      = 48;
    localparam int OUT_W       = 32;
    localparam int Q_W         = 31;
    localparam int VEL_P_W     = STEP_W + RATE_W;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = Q_W;
    localparam int DIV_D_W = 8;

    localparam logic [Q_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [1:0] CFG_LINEAR_GAIN  = 2'd0;
    localparam logic [1:0] CFG_ANGULAR_GAIN = 2'd1;
    localparam logic [1:0] CFG_UPDATE_RATE  = 2'd2;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    function automatic logic [DIV_D_W-1:0] sin_div(input logic [2:0] idx);
        logic [DIV_D_W-1:0] v;
        case (idx)
            3'd0:    v = 8'd110;
            3'd1:    v = 8'd72;
            3'd2:    v = 8'd42;
            3'd3:    v = 8'd20;
            default: v = 8'd6;
        endcase
        return v;
    endfunction

    function automatic logic [DIV_D_W-1:0] cos_div(input logic [2:0] idx);
        logic [DIV_D_W-1:0] v;
        case (idx)
            3'd0:    v = 8'd132;
            3'd1:    v = 8'd90;
            3'd2:    v = 8'd56;
            3'd3:    v = 8'd30;
            3'd4:    v = 8'd12;
            default: v = 8'd2;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/mwo_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on mwo_pkg for the operand widths and the request struct.
module mwo_mul import mwo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_product
);

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_p;
    logic [MUL_A_W:0]   n_sum;

    always_comb begin
        n_sum = {1'b0, r_p[MUL_P_W-1 -: MUL_A_W]} + (r_p[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_req.a;
                r_p    <= {{MUL_A_W{1'b0}}, i_req.b};
            end else if (r_busy) begin
                r_p   <= {n_sum, r_p[MUL_B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

>>> rtl/mwo_div.sv
// Bit-serial restoring divider by a small divisor, one quotient bit per cycle.
// Depends on mwo_pkg for the operand widths and the request struct.
module mwo_div import mwo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_w;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W:0]   n_trial;
    logic [DIV_D_W:0]   n_diff;
    logic               n_ge;

    always_comb begin
        n_trial = {r_rem, r_w[DIV_N_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_w    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DIV_D_W-1:0] : n_trial[DIV_D_W-1:0];
                r_w   <= {r_w[DIV_N_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_w;

endmodule

>>> rtl/mecanum_wheel_odometry_unit.sv
// Top level of the mecanum wheel odometry unit: sequencer, state and ports.
// Depends on mwo_pkg, mwo_mul and mwo_div.
//
// One input beat per odometry period carries four wheel tick counts in tdata
// and four reverse flags in tuser. The unit forms the wheel deltas, scales
// them by the gains, rotates the body step by the old heading with a Taylor
// series sin/cos, integrates pose and heading and returns one output beat
// with pose, heading and body velocities.
// The configuration channel is always ready; write it only while idle.
// All products and quotients run through one bit-serial multiplier and one
// bit-serial divider. One item takes 24 products and 11 quotients from input
// beat to output beat, plus four single steps. Items are taken one at a time:
// s_tready is high only while the sequencer is idle.
// The output beat sits in a register; a stalled receiver holds the finished
// result there, and the next result waits at the end of its computation
// until the register is free.
// Reset clears wheel snapshots, pose and heading, and loads the default gains
// (134929, 53687) and an update rate of 50.
module mecanum_wheel_odometry_unit import mwo_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TRIG_BITS   = TRIG_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // count_front_left, count_front_right, count_rear_left, count_rear_right
    input  logic [127:0] i_s_tdata,
    // reverse_front_left, reverse_front_right, reverse_rear_left, reverse_rear_right
    input  logic [3:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // position_x, position_y, heading_turns, velocity_x, velocity_y, yaw_rate
    output logic [191:0] o_m_tdata
);

    localparam int RND_SH = 30 - TRIG_BITS;
    localparam int TV_W   = TRIG_BITS + 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SUM  = 5'd1;
    localparam logic [4:0] S_GX   = 5'd2;
    localparam logic [4:0] S_GY   = 5'd3;
    localparam logic [4:0] S_GW   = 5'd4;
    localparam logic [4:0] S_RED  = 5'd5;
    localparam logic [4:0] S_XM   = 5'd6;
    localparam logic [4:0] S_X2   = 5'd7;
    localparam logic [4:0] S_SM   = 5'd8;
    localparam logic [4:0] S_SD   = 5'd9;
    localparam logic [4:0] S_SN   = 5'd10;
    localparam logic [4:0] S_CM   = 5'd11;
    localparam logic [4:0] S_CD   = 5'd12;
    localparam logic [4:0] S_RND  = 5'd13;
    localparam logic [4:0] S_R1   = 5'd14;
    localparam logic [4:0] S_R2   = 5'd15;
    localparam logic [4:0] S_R3   = 5'd16;
    localparam logic [4:0] S_R4   = 5'd17;
    localparam logic [4:0] S_POSE = 5'd18;
    localparam logic [4:0] S_V1   = 5'd19;
    localparam logic [4:0] S_V2   = 5'd20;
    localparam logic [4:0] S_V3   = 5'd21;
    localparam logic [4:0] S_DONE = 5'd22;

    logic [4:0]             r_state;
    logic                   r_issued;
    logic [GAIN_W-1:0]      r_lin;
    logic [GAIN_W-1:0]      r_ang;
    logic [RATE_W-1:0]      r_rate;
    logic [COUNT_WIDTH-1:0] r_prev [4];
    logic [SUM_W-1:0]       r_d [4];
    logic [SUM_W-1:0]       r_sx, r_sy, r_sw;
    logic [STEP_W-1:0]      r_dx_mag, r_dy_mag, r_dw_mag;
    logic                   r_dx_neg, r_dy_neg, r_dw_neg;
    logic [31:0]            r_hdelta;
    logic [31:0]            r_head;
    logic [POSE_W-1:0]      r_px, r_py;
    logic [1:0]             r_quad;
    logic                   r_swap;
    logic [Q_W-1:0]         r_x, r_x2, r_t, r_q, r_sn;
    logic [2:0]             r_i;
    logic [TV_W-1:0]        r_s_mag, r_c_mag;
    logic                   r_s_neg, r_c_neg;
    logic [POSE_W:0]        r_p1, r_p2, r_p3, r_p4;
    logic [OUT_W-1:0]       r_vx, r_vy, r_vw;
    logic                   r_out_valid;
    logic [191:0]           r_out;

    logic                   s_acc;
    logic [COUNT_WIDTH-1:0] n_diff [4];
    logic [SUM_W-1:0]       n_d [4];
    logic [SUM_W-1:0]       n_sx, n_sy, n_sw;
    logic [SUM_W-1:0]       n_mx, n_my, n_mw;
    t_mul_req               mul_req;
    t_div_req               div_req;
    logic                   mul_on, div_on;
    logic                   mul_done, div_done;
    logic [MUL_P_W-1:0]     mul_p;
    logic [DIV_N_W-1:0]     div_q;
    logic [STEP_W-1:0]      n_clamp;
    logic [Q_W-1:0]         n_q30;
    logic [POSE_W-1:0]      n_tmag;
    logic [POSE_W:0]        n_tpos, n_tneg;
    logic [VEL_P_W:0]       n_vs;
    logic [VEL_P_W-16:0]    n_vsh;
    logic [OUT_W-1:0]       n_vsat;
    logic                   n_vneg;
    logic [29:0]            n_rr;
    logic                   n_swap;
    logic [31:0]            n_rs, n_rc;
    logic [TV_W-1:0]        n_a, n_b, n_pa, n_pb;
    logic [POSE_W+1:0]      n_sumx, n_sumy;
    logic [POSE_W-1:0]      n_satx, n_saty;

    assign s_acc       = i_s_tvalid & o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_diff[k] = i_s_tdata[k*CNT_FIELD_W +: COUNT_WIDTH] - r_prev[k];
            n_d[k] = {{(SUM_W-COUNT_WIDTH){n_diff[k][COUNT_WIDTH-1]}}, n_diff[k]};
            if (i_s_tuser[k]) begin
                n_d[k] = -n_d[k];
            end
        end
        n_sx = r_d[0] + r_d[1] + r_d[2] + r_d[3];
        n_sy = r_d[1] + r_d[2] - r_d[0] - r_d[3];
        n_sw = r_d[1] + r_d[3] - r_d[0] - r_d[2];
        n_mx = r_sx[SUM_W-1] ? -r_sx : r_sx;
        n_my = r_sy[SUM_W-1] ? -r_sy : r_sy;
        n_mw = r_sw[SUM_W-1] ? -r_sw : r_sw;
    end

    always_comb begin
        mul_on      = 1'b0;
        mul_req.a   = '0;
        mul_req.b   = '0;
        unique case (r_state)
            S_GX: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(n_mx); mul_req.b = r_lin;
            end
            S_GY: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(n_my); mul_req.b = r_lin;
            end
            S_GW: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(n_mw); mul_req.b = r_ang;
            end
            S_XM: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_x); mul_req.b = MUL_B_W'(HALF_PI_Q30);
            end
            S_X2: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_x); mul_req.b = MUL_B_W'(r_x);
            end
            S_SM, S_CM: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_x2); mul_req.b = MUL_B_W'(r_t);
            end
            S_SN: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_x); mul_req.b = MUL_B_W'(r_t);
            end
            S_R1: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dx_mag); mul_req.b = MUL_B_W'(r_c_mag);
            end
            S_R2: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dy_mag); mul_req.b = MUL_B_W'(r_s_mag);
            end
            S_R3: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dx_mag); mul_req.b = MUL_B_W'(r_s_mag);
            end
            S_R4: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dy_mag); mul_req.b = MUL_B_W'(r_c_mag);
            end
            S_V1: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dx_mag); mul_req.b = MUL_B_W'(r_rate);
            end
            S_V2: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dy_mag); mul_req.b = MUL_B_W'(r_rate);
            end
            S_V3: begin
                mul_on = 1'b1; mul_req.a = MUL_A_W'(r_dw_mag); mul_req.b = MUL_B_W'(r_rate);
            end
            default: begin
                mul_on = 1'b0;
            end
        endcase
        mul_req.start = mul_on & ~r_issued;
        div_on        = (r_state == S_SD) || (r_state == S_CD);
        div_req.start = div_on & ~r_issued;
        div_req.num   = r_q;
        div_req.den   = (r_state == S_SD) ? sin_div(r_i) : cos_div(r_i);
    end

    mwo_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    mwo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        n_clamp = (|mul_p[MUL_P_W-1:STEP_W]) ? {STEP_W{1'b1}} : mul_p[STEP_W-1:0];
        n_q30   = mul_p[30 +: Q_W];
        n_tmag  = mul_p[TRIG_BITS +: POSE_W];
        n_tpos  = {1'b0, n_tmag};
        n_tneg  = -n_tpos;

        case (r_state)
            S_V1:    n_vneg = r_dx_neg;
            S_V2:    n_vneg = r_dy_neg;
            default: n_vneg = r_dw_neg;
        endcase
        n_vs  = n_vneg ? -{1'b0, mul_p[VEL_P_W-1:0]} : {1'b0, mul_p[VEL_P_W-1:0]};
        n_vsh = n_vs[VEL_P_W:16];
        if (n_vsh[VEL_P_W-16:OUT_W-1] == '0 || n_vsh[VEL_P_W-16:OUT_W-1] == '1) begin
            n_vsat = n_vsh[OUT_W-1:0];
        end else if (n_vsh[VEL_P_W-16]) begin
            n_vsat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            n_vsat = {1'b0, {(OUT_W-1){1'b1}}};
        end

        n_rr   = r_head[29:0];
        n_swap = (n_rr > 30'h2000_0000);

        n_rs = {1'b0, r_sn} + (32'd1 << (RND_SH - 1));
        n_rc = {1'b0, r_t} + (32'd1 << (RND_SH - 1));
        n_a  = n_rs[RND_SH +: TV_W];
        n_b  = n_rc[RND_SH +: TV_W];
        n_pa = r_swap ? n_b : n_a;
        n_pb = r_swap ? n_a : n_b;

        n_sumx = {{2{r_px[POSE_W-1]}}, r_px} + {r_p1[POSE_W], r_p1} - {r_p2[POSE_W], r_p2};
        n_sumy = {{2{r_py[POSE_W-1]}}, r_py} + {r_p3[POSE_W], r_p3} + {r_p4[POSE_W], r_p4};
        if (n_sumx[POSE_W+1:POSE_W-1] == '0 || n_sumx[POSE_W+1:POSE_W-1] == '1) begin
            n_satx = n_sumx[POSE_W-1:0];
        end else if (n_sumx[POSE_W+1]) begin
            n_satx = {1'b1, {(POSE_W-1){1'b0}}};
        end else begin
            n_satx = {1'b0, {(POSE_W-1){1'b1}}};
        end
        if (n_sumy[POSE_W+1:POSE_W-1] == '0 || n_sumy[POSE_W+1:POSE_W-1] == '1) begin
            n_saty = n_sumy[POSE_W-1:0];
        end else if (n_sumy[POSE_W+1]) begin
            n_saty = {1'b1, {(POSE_W-1){1'b0}}};
        end else begin
            n_saty = {1'b0, {(POSE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= GAIN_W'(134929);
            r_ang <= GAIN_W'(53687);
            r_rate <= RATE_W'(50);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINEAR_GAIN:  r_lin  <= i_cfg_data;
                CFG_ANGULAR_GAIN: r_ang  <= i_cfg_data;
                CFG_UPDATE_RATE:  r_rate <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            for (int k = 0; k < 4; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            if (mul_req.start || div_req.start) begin
                r_issued <= 1'b1;
            end
            if (mul_done || div_done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        for (int k = 0; k < 4; k++) begin
                            r_d[k]    <= n_d[k];
                            r_prev[k] <= i_s_tdata[k*CNT_FIELD_W +: COUNT_WIDTH];
                        end
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sx <= n_sx;
                    r_sy <= n_sy;
                    r_sw <= n_sw;
                    r_state <= S_GX;
                end
                S_GX: begin
                    if (mul_done) begin
                        r_dx_mag <= n_clamp; r_dx_neg <= r_sx[SUM_W-1]; r_state <= S_GY;
                    end
                end
                S_GY: begin
                    if (mul_done) begin
                        r_dy_mag <= n_clamp; r_dy_neg <= r_sy[SUM_W-1]; r_state <= S_GW;
                    end
                end
                S_GW: begin
                    if (mul_done) begin
                        r_dw_mag <= n_clamp;
                        r_dw_neg <= r_sw[SUM_W-1];
                        r_hdelta <= r_sw[SUM_W-1] ? -mul_p[31:0] : mul_p[31:0];
                        r_state  <= S_RED;
                    end
                end
                S_RED: begin
                    r_quad  <= r_head[31:30];
                    r_swap  <= n_swap;
                    r_x     <= n_swap ? (Q30_ONE - {1'b0, n_rr}) : {1'b0, n_rr};
                    r_state <= S_XM;
                end
                S_XM: begin
                    if (mul_done) begin
                        r_x <= n_q30; r_state <= S_X2;
                    end
                end
                S_X2: begin
                    if (mul_done) begin
                        r_x2 <= n_q30; r_t <= Q30_ONE; r_i <= '0; r_state <= S_SM;
                    end
                end
                S_SM: begin
                    if (mul_done) begin
                        r_q <= n_q30; r_state <= S_SD;
                    end
                end
                S_SD: begin
                    if (div_done) begin
                        r_t <= Q30_ONE - div_q;
                        if (r_i == 3'd4) begin
                            r_i <= '0; r_state <= S_SN;
                        end else begin
                            r_i <= r_i + 1'b1; r_state <= S_SM;
                        end
                    end
                end
                S_SN: begin
                    if (mul_done) begin
                        r_sn <= n_q30; r_t <= Q30_ONE; r_state <= S_CM;
                    end
                end
                S_CM: begin
                    if (mul_done) begin
                        r_q <= n_q30; r_state <= S_CD;
                    end
                end
                S_CD: begin
                    if (div_done) begin
                        r_t <= Q30_ONE - div_q;
                        if (r_i == 3'd5) begin
                            r_i <= '0; r_state <= S_RND;
                        end else begin
                            r_i <= r_i + 1'b1; r_state <= S_CM;
                        end
                    end
                end
                S_RND: begin
                    case (r_quad)
                        2'd0: begin
                            r_s_mag <= n_pa; r_s_neg <= 1'b0;
                            r_c_mag <= n_pb; r_c_neg <= 1'b0;
                        end
                        2'd1: begin
                            r_s_mag <= n_pb; r_s_neg <= 1'b0;
                            r_c_mag <= n_pa; r_c_neg <= 1'b1;
                        end
                        2'd2: begin
                            r_s_mag <= n_pa; r_s_neg <= 1'b1;
                            r_c_mag <= n_pb; r_c_neg <= 1'b1;
                        end
                        default: begin
                            r_s_mag <= n_pb; r_s_neg <= 1'b1;
                            r_c_mag <= n_pa; r_c_neg <= 1'b0;
                        end
                    endcase
                    r_state <= S_R1;
                end
                S_R1: begin
                    if (mul_done) begin
                        r_p1 <= (r_dx_neg ^ r_c_neg) ? n_tneg : n_tpos; r_state <= S_R2;
                    end
                end
                S_R2: begin
                    if (mul_done) begin
                        r_p2 <= (r_dy_neg ^ r_s_neg) ? n_tneg : n_tpos; r_state <= S_R3;
                    end
                end
                S_R3: begin
                    if (mul_done) begin
                        r_p3 <= (r_dx_neg ^ r_s_neg) ? n_tneg : n_tpos; r_state <= S_R4;
                    end
                end
                S_R4: begin
                    if (mul_done) begin
                        r_p4 <= (r_dy_neg ^ r_c_neg) ? n_tneg : n_tpos; r_state <= S_POSE;
                    end
                end
                S_POSE: begin
                    r_px    <= n_satx;
                    r_py    <= n_saty;
                    r_head  <= r_head + r_hdelta;
                    r_state <= S_V1;
                end
                S_V1: begin
                    if (mul_done) begin
                        r_vx <= n_vsat; r_state <= S_V2;
                    end
                end
                S_V2: begin
                    if (mul_done) begin
                        r_vy <= n_vsat; r_state <= S_V3;
                    end
                end
                S_V3: begin
                    if (mul_done) begin
                        r_vw <= n_vsat; r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out <= {r_vw, r_vy, r_vx, r_head,
                                  r_py[POSE_W-1:16], r_px[POSE_W-1:16]};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    a_mul_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> r_issued)
        else $error("arithmetic unit finished without a request");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("finished result overwrote a stalled output beat");

    a_no_double_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");
`endif

endmodule

>>> test/mecanum_wheel_odometry_unit_tb.sv
// Self-checking testbench of mecanum_wheel_odometry_unit: directed table, then random runs.
// Results are checked against a dead-reckoning predictor kept in this file; depends on mwo_pkg.
module mecanum_wheel_odometry_unit_tb import mwo_pkg::*;;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 5000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        bit [31:0]  cnt [4];
        bit [3:0]   rev;
        bit         has_res;
        bit [191:0] res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // count_front_left, count_front_right, count_rear_left, count_rear_right
    logic [127:0] i_s_tdata;
    // reverse_front_left, reverse_front_right, reverse_rear_left, reverse_rear_right
    logic [3:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // position_x, position_y, heading_turns, velocity_x, velocity_y, yaw_rate
    logic [191:0] o_m_tdata;

    mecanum_wheel_odometry_unit i_dut (.*);

    bit [31:0]    lin_gain;
    bit [31:0]    ang_gain;
    bit [9:0]     rate_hz;
    bit [31:0]    last_cnt [4];
    longint       pose_x;
    longint       pose_y;
    bit [31:0]    heading;
    bit [191:0]   pose_q [$];
    int           errors;
    t_idle_mode   idle_mode;
    bit           hold_req;
    int           quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint gain_scale(input longint s, input bit [31:0] g);
        bit        neg;
        bit [63:0] m, ph, pl, r;
        neg = s < 0;
        m   = neg ? -s : s;
        ph  = (m >> 32) * g;
        pl  = (m & 64'hFFFF_FFFF) * g;
        if (ph >= 64'd32768 || pl[63]) begin
            r = (64'd1 << 47) - 1;
        end else begin
            r = (ph << 32) + pl;
            if (r > (64'd1 << 47) - 1) r = (64'd1 << 47) - 1;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic void sincos(input bit [31:0] h, output longint sn, output longint cs);
        int        sdiv [5] = '{110, 72, 42, 20, 6};
        int        cdiv [6] = '{132, 90, 56, 30, 12, 2};
        bit [63:0] r, x, x2, t, s_mag, c_mag, a, b, k;
        bit [1:0]  quad;
        bit        swap;
        quad = h[31:30];
        r    = h[29:0];
        swap = r > (64'd1 << 29);
        if (swap) r = (64'd1 << 30) - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / sdiv[i];
        s_mag = (x * t) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / cdiv[i];
        c_mag = t;
        a = (s_mag + (64'd1 << 13)) >> 14;
        b = (c_mag + (64'd1 << 13)) >> 14;
        if (swap) begin
            k = a;
            a = b;
            b = k;
        end
        case (quad)
            2'd0: begin sn = a;  cs = b;  end
            2'd1: begin sn = b;  cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endfunction

    function automatic longint trig_mul(input longint v, input longint t);
        bit        neg;
        bit [63:0] m, u, r;
        neg = (v < 0) != (t < 0);
        m   = v < 0 ? -v : v;
        u   = t < 0 ? -t : t;
        r   = (((m >> 32) * u) << 16) + (((m & 64'hFFFF_FFFF) * u) >> 16);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint pose_clamp(input longint v);
        if (v > (64'sd1 <<< 47) - 1) return (64'sd1 <<< 47) - 1;
        if (v < -(64'sd1 <<< 47)) return -(64'sd1 <<< 47);
        return v;
    endfunction

    function automatic bit [31:0] vel_field(input longint step);
        longint v;
        v = (step * longint'(rate_hz)) >>> 16;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic bit [191:0] odometry_advance(input bit [31:0] cnt [4], input bit [3:0] rev);
        longint    d [4];
        longint    sx, sy, sw, dx, dy, dyaw, sn, cs, px, py;
        bit [63:0] hstep;
        for (int i = 0; i < 4; i++) begin
            d[i] = longint'($signed(cnt[i] - last_cnt[i]));
            if (rev[i]) d[i] = -d[i];
            last_cnt[i] = cnt[i];
        end
        sx = d[0] + d[1] + d[2] + d[3];
        sy = -d[0] + d[1] + d[2] - d[3];
        sw = -d[0] + d[1] - d[2] + d[3];
        dx   = gain_scale(sx, lin_gain);
        dy   = gain_scale(sy, lin_gain);
        dyaw = gain_scale(sw, ang_gain);
        sincos(heading, sn, cs);
        pose_x = pose_clamp(pose_x + trig_mul(dx, cs) - trig_mul(dy, sn));
        pose_y = pose_clamp(pose_y + trig_mul(dx, sn) + trig_mul(dy, cs));
        hstep   = sw * longint'(ang_gain);
        heading = heading + hstep[31:0];
        px = pose_x >>> 16;
        py = pose_y >>> 16;
        return {vel_field(dyaw), vel_field(dy), vel_field(dx), heading, py[31:0], px[31:0]};
    endfunction

    task automatic write_reg(input logic [1:0] idx, input bit [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LINEAR_GAIN:  lin_gain = val;
            CFG_ANGULAR_GAIN: ang_gain = val;
            default:          rate_hz  = val[9:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_gains(input bit [31:0] lg, input bit [31:0] ag, input bit [31:0] hz);
        write_reg(CFG_LINEAR_GAIN, lg);
        write_reg(CFG_ANGULAR_GAIN, ag);
        write_reg(CFG_UPDATE_RATE, hz);
    endtask

    // Called at a falling edge; returns at a falling edge with the beat taken.
    task automatic send_counts(input bit [31:0] cnt [4], input bit [3:0] rev,
                               input bit has_res, input bit [191:0] res);
        bit [191:0] want;
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 73) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 38)) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {cnt[3], cnt[2], cnt[1], cnt[0]};
        i_s_tuser  = rev;
        do @(posedge i_clk); while (!o_s_tready);
        want = odometry_advance(cnt, rev);
        pose_q.push_back(has_res ? res : want);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pose_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_run(input t_idle_mode mode, input int n, input bit with_hold);
        bit [31:0] cnt [4];
        bit [3:0]  rev;
        int        span;
        idle_mode = mode;
        for (int k = 0; k < n; k++) begin
            if (with_hold && k == 5) hold_req = 1'b1;
            span = ($urandom_range(9) == 0) ? 2000000 : 3000;
            for (int i = 0; i < 4; i++) begin
                if ($urandom_range(9) == 0) cnt[i] = $urandom;
                else cnt[i] = last_cnt[i] + 32'($urandom_range(2 * span) - span);
            end
            rev = $urandom_range(3) == 0 ? 4'($urandom) : 4'b0000;
            send_counts(cnt, rev, 1'b0, '0);
        end
        drain();
    endtask

    always @(negedge i_clk) begin
        int hold_left;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready = 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            i_m_tready = $urandom_range(99) >= 73;
        end else if (idle_mode == IDLE_BOTH) begin
            i_m_tready = $urandom_range(99) >= 38;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        bit [191:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, o_m_tdata);
                errors++;
            end else begin
                want = pose_q.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (o_m_tdata[f*32 +: 32] !== want[f*32 +: 32]) begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $realtime, f, want[f*32 +: 32], o_m_tdata[f*32 +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        errors       = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        idle_mode    = IDLE_NONE;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b1;
        lin_gain     = 32'd134929;
        ang_gain     = 32'd53687;
        rate_hz      = 10'd50;
        pose_x       = 0;
        pose_y       = 0;
        heading      = '0;
        for (int i = 0; i < 4; i++) last_cnt[i] = '0;

        r.has_res = 1'b0;
        r.res     = '0;
        r.rev     = 4'b0000;
        r.cnt = '{0, 0, 0, 0};                     r.has_res = 1'b1; rows.push_back(r);
        r.has_res = 1'b0;
        r.cnt = '{1000, 1000, 1000, 1000};         rows.push_back(r);
        r.cnt = '{0, 2000, 2000, 0};               rows.push_back(r);
        r.cnt = '{-500, 1500, 1500, -500};         rows.push_back(r);
        r.cnt = '{-900000, 900000, -900000, 900000}; rows.push_back(r);
        r.cnt = '{-2000000, 2000000, -2000000, 2000000}; rows.push_back(r);
        r.rev = 4'b1111;
        r.cnt = '{-1000000, 1000000, -1000000, 1000000}; rows.push_back(r);
        r.rev = 4'b0001; r.cnt = '{5000, 5000, 5000, 5000}; rows.push_back(r);
        r.rev = 4'b0010; r.cnt = '{9000, 9000, 9000, 9000}; rows.push_back(r);
        r.rev = 4'b0100; r.cnt = '{13000, 13000, 13000, 13000}; rows.push_back(r);
        r.rev = 4'b1000; r.cnt = '{17000, 17000, 17000, 17000}; rows.push_back(r);
        r.rev = 4'b0000;
        r.cnt = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; rows.push_back(r);
        r.cnt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; rows.push_back(r);
        r.cnt = '{32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000}; rows.push_back(r);
        r.cnt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0}; rows.push_back(r);
        r.cnt = '{32'h0, 32'h0, 32'h0, 32'h0};     rows.push_back(r);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[n]) send_counts(rows[n].cnt, rows[n].rev, rows[n].has_res, rows[n].res);
        drain();
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1023);
        foreach (rows[n]) send_counts(rows[n].cnt, rows[n].rev, 1'b0, '0);
        drain();
        set_gains(32'd0, 32'd0, 32'd0);
        random_run(IDLE_BOTH, 30, 1'b0);

        set_gains(32'd134929, 32'd53687, 32'd50);
        random_run(IDLE_NONE, 400, 1'b0);
        set_gains($urandom, $urandom_range(50000000), 32'd1000);
        random_run(IDLE_SEND, 400, 1'b0);
        set_gains($urandom_range(2000000), $urandom, 32'd1);
        random_run(IDLE_RECV, 400, 1'b1);
        set_gains($urandom, $urandom, $urandom_range(1023));
        random_run(IDLE_BOTH, 400, 1'b0);
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1023);
        random_run(IDLE_NONE, 200, 1'b0);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/mwo_pkg.sv
rtl/mwo_mul.sv
rtl/mwo_div.sv
rtl/mecanum_wheel_odometry_unit.sv
test/mecanum_wheel_odometry_unit_tb.sv
